@@ rtl/core/rvq_pkg.sv @@
package rvq_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_CODE_BITS = 2'd0;
   localparam csr_index_type CSR_T_SCALE   = 2'd1;

   localparam logic [3:0]  CODE_BITS_RESET = 4'd1;
   localparam logic [23:0] T_SCALE_RESET   = 24'd4096;

   localparam logic [31:0] RECIP_ONE = 32'h1000_0000;
   localparam logic [31:0] RECIP_SAT = 32'hFFFF_FFFF;
   // Any sum at or below this gives a quotient of 2^32 or more.
   localparam logic [39:0] SAT_LIMIT = 40'd2048;
   localparam logic [39:0] ACC_MAX   = 40'hFF_FFFF_FFFF;
   localparam logic [10:0] CNT_MAX   = 11'd2047;

   // One classified element as it travels from the front to the back.
   typedef struct packed {
      logic [7:0]  plane_code;
      logic [7:0]  ex_code;
      logic        sign_bit;
      logic        last;
      logic        msb;
      logic [15:0] mag;
   } elem_type;

   typedef struct packed {
      logic busy;
      logic done;
   } recip_stat_type;

endpackage

@@ rtl/core/rvq_front.sv @@
module rvq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    req_rotated_value,
   input  logic                  req_last,
   input  logic [3:0]            code_bits,
   input  logic [23:0]           t_scale,
   output logic                  push_valid,
   input  logic                  push_ready,
   output rvq_pkg::elem_type     push_data
);

   logic [3:0]         m;
   logic [8:0]         maxc;
   logic signed [16:0] shifted;
   logic [3:0]         shamt;
   logic [15:0]        bin_raw;
   logic [7:0]         bin_cap;
   logic [2:0]         msb_idx;
   logic [15:0]        mag;
   logic [39:0]        prod;
   logic               load;

   logic               f_vld_ff;
   logic [7:0]         f_bin_ff;
   logic               f_sign_ff;
   logic               f_last_ff;
   logic               f_msb_ff;
   logic [15:0]        f_mag_ff;
   logic [12:0]        f_phi_ff;

   always_comb begin
      priority if (code_bits == 4'd0) begin
         m = 4'd1;
      end else if (code_bits > 4'd8) begin
         m = 4'd8;
      end else begin
         m = code_bits;
      end
   end

   assign maxc    = (9'd1 << m) - 9'd1;
   assign shifted = 17'(req_rotated_value) + 17'sd16384;
   assign shamt   = 4'd15 - m;
   assign bin_raw = shifted[16] ? 16'd0 : (shifted[15:0] >> shamt);
   assign bin_cap = (bin_raw > 16'(maxc)) ? maxc[7:0] : bin_raw[7:0];
   assign msb_idx = 3'(m - 4'd1);
   assign mag     = req_rotated_value[15] ? 16'(~req_rotated_value + 16'sd1)
                                          : 16'(req_rotated_value);
   assign prod    = 40'(t_scale) * 40'(mag);

   assign req_ready = !f_vld_ff || push_ready;
   assign load      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (load) begin
         f_vld_ff <= 1'b1;
      end else if (push_ready) begin
         f_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         f_bin_ff  <= bin_cap;
         f_sign_ff <= !req_rotated_value[15];
         f_last_ff <= req_last;
         f_msb_ff  <= bin_cap[msb_idx];
         f_mag_ff  <= mag;
         f_phi_ff  <= prod[38:26];
      end
   end

   // The extended code is only meaningful with more than one bit per element.
   always_comb begin
      push_data.plane_code = f_bin_ff;
      push_data.sign_bit   = f_sign_ff;
      push_data.last       = f_last_ff;
      push_data.msb        = f_msb_ff;
      push_data.mag        = f_mag_ff;
      if (m == 4'd1) begin
         push_data.ex_code = 8'd0;
      end else if (f_phi_ff > 13'(maxc)) begin
         push_data.ex_code = maxc[7:0];
      end else begin
         push_data.ex_code = f_phi_ff[7:0];
      end
   end

   assign push_valid = f_vld_ff;

endmodule

@@ rtl/core/rvq_queue.sv @@
module rvq_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  rvq_pkg::elem_type     push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output rvq_pkg::elem_type     pop_data
);

   rvq_pkg::elem_type            entry_ff [rvq_pkg::QUEUE_DEPTH];
   logic [rvq_pkg::QPTR_W-1:0]   wr_ptr_ff;
   logic [rvq_pkg::QPTR_W-1:0]   rd_ptr_ff;
   logic [rvq_pkg::QPTR_W:0]     count_ff;
   logic                         do_push;
   logic                         do_pop;

   assign push_ready = count_ff != (rvq_pkg::QPTR_W + 1)'(rvq_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/rvq_recip.sv @@
module rvq_recip (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [39:0]              divisor,
   output rvq_pkg::recip_stat_type  stat,
   output logic [31:0]              quotient
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type    state_ff;
   logic [39:0]  d_ff;
   logic [39:0]  r_ff;
   logic [31:0]  q_ff;
   logic [4:0]   cnt_ff;
   logic [40:0]  r_shl;
   logic         ge;

   assign r_shl = {r_ff, 1'b0};
   assign ge    = r_shl >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  if (divisor <= rvq_pkg::SAT_LIMIT) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               if (cnt_ff == 5'd0) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // 2^43 / d: the upper twelve quotient bits are zero once d exceeds 2048,
   // so the remainder starts at 2^11 and 32 restoring steps remain.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               d_ff   <= divisor;
               r_ff   <= 40'd2048;
               cnt_ff <= 5'd31;
               priority if (divisor == 40'd0) begin
                  q_ff <= rvq_pkg::RECIP_ONE;
               end else if (divisor <= rvq_pkg::SAT_LIMIT) begin
                  q_ff <= rvq_pkg::RECIP_SAT;
               end else begin
                  q_ff <= 32'd0;
               end
            end
         end
         ST_RUN: begin
            r_ff   <= ge ? 40'(r_shl - {1'b0, d_ff}) : r_shl[39:0];
            q_ff   <= {q_ff[30:0], ge};
            cnt_ff <= cnt_ff - 5'd1;
         end
         default: begin
         end
      endcase
   end

   assign stat.busy = state_ff != ST_IDLE;
   assign stat.done = state_ff == ST_DONE;
   assign quotient  = q_ff;

endmodule

@@ rtl/core/rvq_back.sv @@
module rvq_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  rvq_pkg::elem_type        pop_data,
   output logic                     recip_start,
   output logic [39:0]              recip_divisor,
   input  rvq_pkg::recip_stat_type  recip_stat,
   input  logic [31:0]              recip_quotient,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_plane_code,
   output logic [7:0]               rsp_ex_code,
   output logic                     rsp_sign_bit,
   output logic                     rsp_end_of_vector,
   output logic [31:0]              rsp_recip_ipnorm,
   output logic [10:0]              rsp_msb_count
);

   logic         m_vld_ff;
   logic [7:0]   m_bin_ff;
   logic [7:0]   m_ex_ff;
   logic         m_sign_ff;
   logic         m_last_ff;
   logic         m_msb_ff;
   logic [24:0]  m_add_ff;
   logic [24:0]  m_add_in;

   logic [39:0]  acc_ff;
   logic [10:0]  cnt_ff;
   logic [40:0]  sum;
   logic [39:0]  acc_in;
   logic [10:0]  cnt_in;

   logic [7:0]   pend_bin_ff;
   logic [7:0]   pend_ex_ff;
   logic         pend_sign_ff;
   logic [10:0]  pend_cnt_ff;

   logic         rsp_valid_ff;
   logic [7:0]   rsp_bin_ff;
   logic [7:0]   rsp_ex_ff;
   logic         rsp_sign_ff;
   logic         rsp_eov_ff;
   logic [31:0]  rsp_recip_ff;
   logic [10:0]  rsp_cnt_ff;

   logic         fire;
   logic         take;

   // The weight (2*ex+1)*|v| is formed when the element leaves the queue.
   assign m_add_in = 25'({pop_data.ex_code, 1'b1}) * 25'(pop_data.mag);

   assign fire      = m_vld_ff && !recip_stat.busy && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !m_vld_ff || fire;
   assign take      = pop_valid && pop_ready;

   assign sum    = {1'b0, acc_ff} + 41'(m_add_ff);
   assign acc_in = sum[40] ? rvq_pkg::ACC_MAX : sum[39:0];
   assign cnt_in = (m_msb_ff && cnt_ff != rvq_pkg::CNT_MAX) ? cnt_ff + 11'd1 : cnt_ff;

   assign recip_start   = fire && m_last_ff;
   assign recip_divisor = acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (take) begin
         m_vld_ff <= 1'b1;
      end else if (fire) begin
         m_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         m_bin_ff  <= pop_data.plane_code;
         m_ex_ff   <= pop_data.ex_code;
         m_sign_ff <= pop_data.sign_bit;
         m_last_ff <= pop_data.last;
         m_msb_ff  <= pop_data.msb;
         m_add_ff  <= m_add_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (fire) begin
         if (m_last_ff) begin
            acc_ff <= '0;
            cnt_ff <= '0;
         end else begin
            acc_ff <= acc_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   // The last item of a vector waits here while the reciprocal is worked out.
   always_ff @(posedge clock) begin
      if (fire && m_last_ff) begin
         pend_bin_ff  <= m_bin_ff;
         pend_ex_ff   <= m_ex_ff;
         pend_sign_ff <= m_sign_ff;
         pend_cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (recip_stat.done || (fire && !m_last_ff)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (recip_stat.done) begin
         rsp_bin_ff   <= pend_bin_ff;
         rsp_ex_ff    <= pend_ex_ff;
         rsp_sign_ff  <= pend_sign_ff;
         rsp_eov_ff   <= 1'b1;
         rsp_recip_ff <= recip_quotient;
         rsp_cnt_ff   <= pend_cnt_ff;
      end else if (fire && !m_last_ff) begin
         rsp_bin_ff   <= m_bin_ff;
         rsp_ex_ff    <= m_ex_ff;
         rsp_sign_ff  <= m_sign_ff;
         rsp_eov_ff   <= 1'b0;
         rsp_recip_ff <= 32'd0;
         rsp_cnt_ff   <= 11'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_plane_code    = rsp_bin_ff;
   assign rsp_ex_code       = rsp_ex_ff;
   assign rsp_sign_bit      = rsp_sign_ff;
   assign rsp_end_of_vector = rsp_eov_ff;
   assign rsp_recip_ipnorm  = rsp_recip_ff;
   assign rsp_msb_count     = rsp_cnt_ff;

   a_done_shows_last: assert property (@(posedge clock) disable iff (reset)
      recip_stat.done |=> rsp_valid_ff && rsp_eov_ff)
      else $error("finished reciprocal did not reach the result register");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      fire && m_last_ff |=> acc_ff == 40'd0 && cnt_ff == 11'd0)
      else $error("sums not cleared after the last item of a vector");

   a_mid_vector_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_eov_ff |-> rsp_recip_ff == 32'd0 && rsp_cnt_ff == 11'd0)
      else $error("vector totals shown on an item that is not the last");

endmodule

@@ rtl/core/rotated_vector_quantizer.sv @@
// Rotated vector quantizer: codes the elements of one rotated unit vector.
// Items enter on req_* one element at a time (Q2.14), req_last on the final
// element. Each item gives exactly one result on rsp_*: the bin code, the
// extended code and the sign. The result of the last element also carries
// the reciprocal of the accumulated inner product (Q4.28) and the count of
// most significant bin-code bits set; both are zero on other results.
// The csr_* port writes code_bits (index 0) and t_scale (index 1); it is
// always ready and should only be written while no item is in flight.
// A front stage classifies each item and pushes it into a four-entry queue;
// the back stage accumulates and produces results. Ordinary elements pass at
// one per cycle while rsp_ready is high and no divider runs; each result is
// registered in the front stage, the queue, the back stage and the result
// register. The last element of a vector holds the back stage while a
// restoring divider runs for a sum above 2048; a sum that is zero or saturates
// sends the divider straight to its done state.
// While rsp_ready is low the result register holds and the queue fills, then
// req_ready drops. Reset empties the pipeline, clears the sums and sets
// code_bits to 1 and t_scale to 1.0.
module rotated_vector_quantizer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [15:0]           req_rotated_value,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_plane_code,
   output logic [7:0]                   rsp_ex_code,
   output logic                         rsp_sign_bit,
   output logic                         rsp_end_of_vector,
   output logic [31:0]                  rsp_recip_ipnorm,
   output logic [10:0]                  rsp_msb_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  rvq_pkg::csr_index_type       csr_index,
   input  logic [23:0]                  csr_data
);

   logic [3:0]                code_bits_ff;
   logic [23:0]               t_scale_ff;

   logic                      push_valid;
   logic                      push_ready;
   rvq_pkg::elem_type         push_data;
   logic                      pop_valid;
   logic                      pop_ready;
   rvq_pkg::elem_type         pop_data;
   logic                      recip_start;
   logic [39:0]               recip_divisor;
   rvq_pkg::recip_stat_type   recip_stat;
   logic [31:0]               recip_quotient;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_bits_ff <= rvq_pkg::CODE_BITS_RESET;
         t_scale_ff   <= rvq_pkg::T_SCALE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            rvq_pkg::CSR_CODE_BITS: code_bits_ff <= csr_data[3:0];
            rvq_pkg::CSR_T_SCALE:   t_scale_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   rvq_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rotated_value (req_rotated_value),
      .req_last          (req_last),
      .code_bits         (code_bits_ff),
      .t_scale           (t_scale_ff),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_data         (push_data)
   );

   rvq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rvq_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (recip_start),
      .divisor  (recip_divisor),
      .stat     (recip_stat),
      .quotient (recip_quotient)
   );

   rvq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .recip_start       (recip_start),
      .recip_divisor     (recip_divisor),
      .recip_stat        (recip_stat),
      .recip_quotient    (recip_quotient),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_plane_code    (rsp_plane_code),
      .rsp_ex_code       (rsp_ex_code),
      .rsp_sign_bit      (rsp_sign_bit),
      .rsp_end_of_vector (rsp_end_of_vector),
      .rsp_recip_ipnorm  (rsp_recip_ipnorm),
      .rsp_msb_count     (rsp_msb_count)
   );

endmodule

@@ tb/sv/rvq_result_checker.sv @@
`timescale 1ns / 1ps
module rvq_result_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic signed [15:0]     req_rotated_value,
   input  logic                   req_last,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [7:0]             rsp_plane_code,
   input  logic [7:0]             rsp_ex_code,
   input  logic                   rsp_sign_bit,
   input  logic                   rsp_end_of_vector,
   input  logic [31:0]            rsp_recip_ipnorm,
   input  logic [10:0]            rsp_msb_count,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  rvq_pkg::csr_index_type csr_index,
   input  logic [23:0]            csr_data,
   output int                     mismatch_count,
   output int                     pending_results
);

   typedef struct packed {
      logic [7:0]  plane_code;
      logic [7:0]  ex_code;
      logic        sign_bit;
      logic        end_of_vector;
      logic [31:0] recip_ipnorm;
      logic [10:0] msb_count;
   } code_result_type;

   code_result_type expected_codes[$];

   logic [3:0]  code_bits;
   logic [23:0] t_scale;
   logic [39:0] ip_sum;
   logic [10:0] msb_ones;

   // Codes one element and advances the running sum and count of the vector.
   task automatic quantize_element(input logic signed [15:0] value, input logic last,
                                   output code_result_type res);
      int unsigned     m;
      int unsigned     top_code;
      int              shifted;
      int unsigned     mag;
      int unsigned     bin;
      longint unsigned ex;
      longint unsigned step_add;
      longint unsigned quot;
      m = (code_bits == 4'd0) ? 1 : (code_bits > 4'd8) ? 8 : int'(code_bits);
      top_code = (1 << m) - 1;
      mag = (value < 0) ? unsigned'(-int'(value)) : unsigned'(int'(value));
      shifted = int'(value) + 16384;
      bin = (shifted < 0) ? 0 : unsigned'(shifted) >> (15 - m);
      if (bin > top_code) begin
         bin = top_code;
      end
      if (m == 1) begin
         ex = 0;
      end else begin
         ex = (64'(t_scale) * 64'(mag)) >> 26;
         if (ex > top_code) begin
            ex = top_code;
         end
      end
      step_add = (2 * ex + 1) * 64'(mag);
      if (64'(ip_sum) > 64'(rvq_pkg::ACC_MAX) - step_add) begin
         ip_sum = rvq_pkg::ACC_MAX;
      end else begin
         ip_sum = ip_sum + 40'(step_add);
      end
      if (((bin >> (m - 1)) & 1) != 0 && msb_ones != rvq_pkg::CNT_MAX) begin
         msb_ones = msb_ones + 11'd1;
      end
      res.plane_code    = bin[7:0];
      res.ex_code       = ex[7:0];
      res.sign_bit      = (value >= 0);
      res.end_of_vector = last;
      res.recip_ipnorm  = '0;
      res.msb_count     = '0;
      if (last) begin
         if (ip_sum == '0) begin
            res.recip_ipnorm = rvq_pkg::RECIP_ONE;
         end else begin
            quot = (64'd1 << 43) / 64'(ip_sum);
            res.recip_ipnorm = (quot > 64'hFFFF_FFFF) ? rvq_pkg::RECIP_SAT : quot[31:0];
         end
         res.msb_count = msb_ones;
         ip_sum = '0;
         msb_ones = '0;
      end
   endtask

   task automatic compare_field(input string field, input longint unsigned want,
                                input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      code_result_type predicted;
      code_result_type oldest;
      if (reset) begin
         code_bits = rvq_pkg::CODE_BITS_RESET;
         t_scale = rvq_pkg::T_SCALE_RESET;
         ip_sum = '0;
         msb_ones = '0;
         expected_codes.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rvq_pkg::CSR_CODE_BITS: code_bits = csr_data[3:0];
               rvq_pkg::CSR_T_SCALE:   t_scale = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            quantize_element(req_rotated_value, req_last, predicted);
            expected_codes.insert(expected_codes.size(), predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               $error("result item arrived with no item outstanding");
               mismatch_count++;
            end else begin
               oldest = expected_codes.pop_front();
               compare_field("plane_code", 64'(oldest.plane_code), 64'(rsp_plane_code));
               compare_field("ex_code", 64'(oldest.ex_code), 64'(rsp_ex_code));
               compare_field("sign_bit", 64'(oldest.sign_bit), 64'(rsp_sign_bit));
               compare_field("end_of_vector", 64'(oldest.end_of_vector),
                             64'(rsp_end_of_vector));
               compare_field("recip_ipnorm", 64'(oldest.recip_ipnorm),
                             64'(rsp_recip_ipnorm));
               compare_field("msb_count", 64'(oldest.msb_count), 64'(rsp_msb_count));
            end
         end
      end
      pending_results = expected_codes.size();
   end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

   localparam int unsigned RUN_LIMIT = 600000;
   localparam int unsigned ITEMS_PER_PHASE = 410;
   localparam int unsigned ITEMS_PER_SETTING = 70;
   localparam rvq_pkg::csr_index_type CSR_SPARE_LO = 2'd2;
   localparam rvq_pkg::csr_index_type CSR_SPARE_HI = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic signed [15:0]     req_rotated_value = '0;
   logic                   req_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_plane_code;
   logic [7:0]             rsp_ex_code;
   logic                   rsp_sign_bit;
   logic                   rsp_end_of_vector;
   logic [31:0]            rsp_recip_ipnorm;
   logic [10:0]            rsp_msb_count;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   rvq_pkg::csr_index_type csr_index = rvq_pkg::CSR_CODE_BITS;
   logic [23:0]            csr_data = '0;

   int          mismatch_count;
   int          pending_results;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned cycle_count = 0;

   rotated_vector_quantizer dut (.*);

   rvq_result_checker checker_inst (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("rotated_vector_quantizer test failed");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_element(input logic signed [15:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rotated_value <= value;
      req_last <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_register(input rvq_pkg::csr_index_type idx, input logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_codec(input logic [23:0] bits_word, input logic [23:0] scale);
      write_register(rvq_pkg::CSR_CODE_BITS, bits_word);
      write_register(rvq_pkg::CSR_T_SCALE, scale);
      csr_valid <= 1'b0;
   endtask

   // Registers change only once every result of earlier items is back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic signed [15:0] random_element();
      int unsigned pick;
      int unsigned which;
      pick = $urandom_range(99);
      which = $urandom_range(6);
      if (pick < 60) return 16'(int'($urandom_range(32768)) - 16384);
      if (pick < 75) return 16'(int'($urandom_range(64)) - 32);
      if (pick < 85) begin
         case (which)
            0: return -16'sd16384;
            1: return 16'sd16384;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            5: return 16'sh8000;
            default: return 16'sh7FFF;
         endcase
      end
      return 16'($urandom_range(65535));
   endfunction

   task automatic pick_random_codec();
      logic [23:0] bits_word;
      logic [23:0] scale;
      bits_word = {20'($urandom_range(20'hFFFFF)), 4'($urandom_range(15))};
      case ($urandom_range(9))
         0: scale = '0;
         1: scale = 24'hFF_FFFF;
         2, 3: scale = 24'($urandom_range(24'hFF_FFFF));
         default: scale = 24'($urandom_range(1 << 20));
      endcase
      set_codec(bits_word, scale);
   endtask

   task automatic send_vector(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
         send_element(random_element(), i == len - 1);
      end
   endtask

   task automatic run_phase(input int unsigned idle, input int unsigned stall);
      int unsigned sent;
      int unsigned in_setting;
      int unsigned len;
      send_idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
         drain();
         pick_random_codec();
         in_setting = 0;
         while (in_setting < ITEMS_PER_SETTING && sent < ITEMS_PER_PHASE) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
            send_vector(len);
            sent += len;
            in_setting += len;
         end
      end
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // One-bit mode after reset: zero sum, sums at and around the saturation edge.
      send_element(16'sd0, 1'b1);
      send_element(16'sd1, 1'b1);
      send_element(-16'sd2048, 1'b1);
      send_element(16'sd2049, 1'b1);

      drain();
      set_codec(24'd8, 24'hFF_FFFF);
      send_element(16'sd16384, 1'b0);
      send_element(-16'sd16384, 1'b0);
      send_element(16'sh7FFF, 1'b0);
      send_element(16'sh8000, 1'b0);
      send_element(-16'sd1, 1'b0);
      send_element(16'sd16383, 1'b1);

      // A code width of zero behaves as one bit, and wide ones as eight bits.
      drain();
      set_codec(24'hABCDE0, 24'd0);
      send_element(16'sd100, 1'b0);
      send_element(-16'sd100, 1'b0);
      send_element(16'sd0, 1'b1);

      drain();
      set_codec(24'h00000F, 24'h012345);
      send_element(16'sd8192, 1'b0);
      send_element(-16'sd8192, 1'b0);
      send_element(16'sd16384, 1'b1);

      drain();
      set_codec(24'd3, 24'd28672);
      send_element(-16'sd16385, 1'b0);
      send_element(16'sd16385, 1'b0);
      send_element(-16'sd1, 1'b0);
      send_element(16'sd1, 1'b1);

      // Writes to unused indexes must leave the setting alone.
      drain();
      write_register(CSR_SPARE_LO, 24'h000008);
      write_register(CSR_SPARE_HI, 24'hFF_FFFF);
      csr_valid <= 1'b0;
      send_element(16'sd5000, 1'b0);
      send_element(-16'sd5000, 1'b1);

      run_phase(0, 0);
      run_phase(65, 0);
      run_phase(0, 65);
      run_phase(14, 14);

      drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("rotated_vector_quantizer test passed");
      end else begin
         $display("rotated_vector_quantizer test failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/rvq_pkg.sv
rtl/core/rvq_front.sv
rtl/core/rvq_queue.sv
rtl/core/rvq_recip.sv
rtl/core/rvq_back.sv
rtl/core/rotated_vector_quantizer.sv
tb/sv/rvq_result_checker.sv
tb/sv/tb_top.sv
